@@ hdl/uer_pkg.sv @@
// shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by the controller, the datapath and the top level
package uer_pkg;

   localparam int unsigned INCH_DIVISOR = 148;
   localparam int unsigned MAX_INCHES   = 150;
   localparam int unsigned OUT_OF_RANGE = 255;
   localparam int unsigned TPU_RESET    = 16;
   localparam int unsigned COUNT_WIDTH  = 32;
   localparam int unsigned TPU_WIDTH    = 8;
   localparam int unsigned DIV_WIDTH    = 16;
   localparam int unsigned DIST_WIDTH   = 8;
   localparam int unsigned STEP_WIDTH   = $clog2(COUNT_WIDTH);

   localparam logic OP_RUN_TICK = 1'b0;
   localparam logic OP_CAPTURE  = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_TRIG     = 2'd1,
      PH_RELEASED = 2'd2,
      PH_RUNNING  = 2'd3
   } phase_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic finish;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic measure_hit;
      logic div_last;
      logic out_free;
   } ctrl_status_type;

endpackage

@@ hdl/ultrasonic_echo_ranger.sv @@
// top level of the ultrasonic echo ranger: trigger sequencing and echo timing
// depends on uer_pkg, uer_controller and uer_datapath
//
//   channel   ports                                      direction
//   req       req_valid req_stall req_opcode             in (stall out)
//             req_capture_count
//   rsp       rsp_valid rsp_stall rsp_trigger_level      out (stall in)
//             rsp_timer_enable rsp_distance_value
//   csr       csr_write_enable csr_write_data            in
//
// a run tick or an ignored capture goes from accept through the emit state to its result beat
// the distance-producing capture runs the one-bit-a-step restoring divider, with its
// divisor multiplied at accept, then the distance update and output load
// one item is worked at a time; req_stall is high from accept until its beat
// is loaded into the output register, and a stalled rsp beat holds that load
// reset is synchronous, active high; ticks_per_microsecond returns to 16
module ultrasonic_echo_ranger
   import uer_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration: ticks per microsecond of the capture timer
   input  logic                   csr_write_enable,
   input  logic [TPU_WIDTH-1:0]   csr_write_data,
   // input item: run tick or echo capture
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic [COUNT_WIDTH-1:0] req_capture_count,
   // result item: pin levels and last distance
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_trigger_level,
   output logic                   rsp_timer_enable,
   output logic [DIST_WIDTH-1:0]  rsp_distance_value
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // controller: accept, divide, finish, emit
   uer_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: phase bits, divider, output register
   uer_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_opcode         (req_opcode),
      .req_capture_count  (req_capture_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_trigger_level  (rsp_trigger_level),
      .rsp_timer_enable   (rsp_timer_enable),
      .rsp_distance_value (rsp_distance_value),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

@@ hdl/uer_controller.sv @@
// sequencing state machine for the ultrasonic echo ranger
// depends on uer_pkg; drives commands to uer_datapath
module uer_controller
   import uer_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = status.measure_hit ? ST_DIVIDE : ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.load_out = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

@@ hdl/uer_datapath.sv @@
// phase state, serial divider and output register of the ultrasonic echo ranger
// depends on uer_pkg; commanded by uer_controller
module uer_datapath
   import uer_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [TPU_WIDTH-1:0]   csr_write_data,
   input  logic                   req_opcode,
   input  logic [COUNT_WIDTH-1:0] req_capture_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_trigger_level,
   output logic                   rsp_timer_enable,
   output logic [DIST_WIDTH-1:0]  rsp_distance_value,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        status
);

   logic [TPU_WIDTH-1:0]   tpu_ff;
   phase_type              phase_ff;
   logic                   trigger_ff;
   logic                   timer_ff;
   logic                   ignore_ff;
   logic [DIST_WIDTH-1:0]  distance_ff;
   logic [DIV_WIDTH-1:0]   divisor_ff;
   logic [DIV_WIDTH-1:0]   rem_ff;
   logic [COUNT_WIDTH-1:0] quo_ff;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic                   rsp_valid_ff;
   logic                   out_trigger_ff;
   logic                   out_timer_ff;
   logic [DIST_WIDTH-1:0]  out_distance_ff;

   logic [TPU_WIDTH-1:0]   tpu_eff;
   logic [DIV_WIDTH:0]     trial;
   logic                   fits;
   logic [DIV_WIDTH:0]     diff;

   // zero register value behaves as one tick per microsecond
   assign tpu_eff = (tpu_ff == '0) ? TPU_WIDTH'(1) : tpu_ff;

   // one restoring step: shift in next dividend bit, try subtract
   assign trial = {rem_ff, quo_ff[COUNT_WIDTH-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});
   assign diff  = trial - {1'b0, divisor_ff};

   assign status.measure_hit = (req_opcode == OP_CAPTURE) && (phase_ff == PH_RUNNING);
   assign status.div_last    = (step_ff == STEP_WIDTH'(COUNT_WIDTH - 1));
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff      <= TPU_WIDTH'(TPU_RESET);
         phase_ff    <= PH_IDLE;
         trigger_ff  <= 1'b0;
         timer_ff    <= 1'b0;
         ignore_ff   <= 1'b0;
         distance_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            tpu_ff <= csr_write_data;
         end
         if (cmd.accept) begin
            if (req_opcode == OP_RUN_TICK) begin
               if (phase_ff == PH_IDLE) begin
                  trigger_ff <= 1'b1;
                  phase_ff   <= PH_TRIG;
               end else if (phase_ff == PH_TRIG) begin
                  trigger_ff <= 1'b0;
                  phase_ff   <= PH_RELEASED;
               end
            end else begin
               if (phase_ff == PH_RELEASED) begin
                  timer_ff <= 1'b1;
                  phase_ff <= PH_RUNNING;
               end else if (phase_ff == PH_RUNNING) begin
                  timer_ff <= 1'b0;
                  phase_ff <= PH_IDLE;
               end
            end
         end
         if (cmd.finish) begin
            if (quo_ff > COUNT_WIDTH'(MAX_INCHES)) begin
               distance_ff <= DIST_WIDTH'(OUT_OF_RANGE);
               ignore_ff   <= 1'b1;
            end else if (ignore_ff) begin
               distance_ff <= DIST_WIDTH'(OUT_OF_RANGE);
               ignore_ff   <= 1'b0;
            end else begin
               distance_ff <= quo_ff[DIST_WIDTH-1:0];
            end
         end
      end
   end

   // divider registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.accept && status.measure_hit) begin
         divisor_ff <= DIV_WIDTH'(tpu_eff) * DIV_WIDTH'(INCH_DIVISOR);
         rem_ff     <= '0;
         quo_ff     <= req_capture_count;
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         quo_ff  <= {quo_ff[COUNT_WIDTH-2:0], fits};
         step_ff <= step_ff + STEP_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_trigger_ff  <= trigger_ff;
         out_timer_ff    <= timer_ff;
         out_distance_ff <= distance_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger_level  = out_trigger_ff;
   assign rsp_timer_enable   = out_timer_ff;
   assign rsp_distance_value = out_distance_ff;

`ifndef SYNTHESIS
   a_trig_phase: assert property (@(posedge clock) disable iff (reset)
      trigger_ff == (phase_ff == PH_TRIG))
      else $error("trigger level out of step with phase");

   a_timer_phase: assert property (@(posedge clock) disable iff (reset)
      timer_ff == (phase_ff == PH_RUNNING))
      else $error("timer enable out of step with phase");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while beat pending");
`endif

endmodule

@@ tb/sv/ultrasonic_echo_ranger_test.sv @@
`timescale 1ns / 100ps
// self-checking bench for ultrasonic_echo_ranger: a directed table, then random measure cycles
// depends on uer_pkg and the ultrasonic_echo_ranger rtl; an in-bench predictor checks each beat
module ultrasonic_echo_ranger_test;
   import uer_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400_000;
   // margin over the longest item, a distance capture
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned ITEMS_A_PHASE = 146;
   localparam int unsigned PHASE_COUNT   = 6;
   localparam int unsigned QUIET_PHASE   = 2;
   localparam int unsigned PRINT_CAP     = 20;

   // one result beat as the block reports it
   typedef struct packed {
      logic                  trigger;
      logic                  timer;
      logic [DIST_WIDTH-1:0] distance;
   } reading_type;

   // one directed row: the request beat and, where pinned, its typed-in reading
   typedef struct packed {
      logic                   opcode;
      logic [COUNT_WIDTH-1:0] count;
      logic                   pinned;
      reading_type            want;
   } stim_row_type;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   csr_write_enable   = 1'b0;
   logic [TPU_WIDTH-1:0]   csr_write_data     = '0;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic                   req_opcode         = OP_RUN_TICK;
   logic [COUNT_WIDTH-1:0] req_capture_count  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic                   rsp_trigger_level;
   logic                   rsp_timer_enable;
   logic [DIST_WIDTH-1:0]  rsp_distance_value;

   // side info that travels with the request beat, held stable while stalled
   logic                   row_pinned = 1'b0;
   reading_type            row_want   = '0;

   // when set, neither side inserts idle cycles
   logic                   quiet = 1'b0;

   // predictor state, mirrors the sequencer and echo timing
   phase_type              seq_phase     = PH_IDLE;
   logic                   skip_next     = 1'b0;
   logic [DIST_WIDTH-1:0]  held_distance = '0;
   logic                   trig_pin      = 1'b0;
   logic                   timer_on      = 1'b0;
   logic [TPU_WIDTH-1:0]   tick_rate     = TPU_WIDTH'(TPU_RESET);

   reading_type            expected_readings[$];

   int unsigned            mismatch_count = 0;
   int unsigned            cycle_count    = 0;
   int unsigned            beats_in       = 0;
   int unsigned            beats_out      = 0;
   int unsigned            echoes_sent    = 0;

   // directed table, tick rate at its reset value of 16, so one inch is 2368 ticks
   stim_row_type directed_rows [24] = '{
      // opcode       count            pinned  trig  timer dist
      '{OP_CAPTURE,  32'hFFFF_FFFF,   1'b1, '{1'b0, 1'b0, 8'd0}},   // capture in idle dropped
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b1, 1'b0, 8'd0}},   // trigger pin goes high
      '{OP_CAPTURE,  32'hFFFF_FFFF,   1'b1, '{1'b1, 1'b0, 8'd0}},   // capture while high dropped
      '{OP_RUN_TICK, 32'hFFFF_FFFF,   1'b1, '{1'b0, 1'b0, 8'd0}},   // trigger released
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b0, 1'b0, 8'd0}},   // tick while released, no change
      '{OP_CAPTURE,  32'h0000_0000,   1'b1, '{1'b0, 1'b1, 8'd0}},   // first edge starts the timer
      '{OP_RUN_TICK, 32'hFFFF_FFFF,   1'b1, '{1'b0, 1'b1, 8'd0}},   // tick while running, no change
      '{OP_CAPTURE,  32'h0000_0000,   1'b1, '{1'b0, 1'b0, 8'd0}},   // zero echo time
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b1, 1'b0, 8'd0}},
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b0, 1'b0, 8'd0}},
      '{OP_CAPTURE,  32'hAAAA_AAAA,   1'b1, '{1'b0, 1'b1, 8'd0}},
      '{OP_CAPTURE,  32'd355_200,     1'b1, '{1'b0, 1'b0, 8'd150}}, // top of range, 150 inches
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b1, 1'b0, 8'd150}},
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b0, 1'b0, 8'd150}},
      '{OP_CAPTURE,  32'h5555_5555,   1'b1, '{1'b0, 1'b1, 8'd150}},
      '{OP_CAPTURE,  32'd357_568,     1'b1, '{1'b0, 1'b0, 8'd255}}, // 151 inches, arms the skip
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b1, 1'b0, 8'd255}},
      '{OP_RUN_TICK, 32'h0000_0000,   1'b1, '{1'b0, 1'b0, 8'd255}},
      '{OP_CAPTURE,  32'h0000_0000,   1'b1, '{1'b0, 1'b1, 8'd255}},
      '{OP_CAPTURE,  32'd357_567,     1'b1, '{1'b0, 1'b0, 8'd255}}, // in range but skipped
      '{OP_RUN_TICK, 32'h1234_5678,   1'b0, '0},
      '{OP_RUN_TICK, 32'h8765_4321,   1'b0, '0},
      '{OP_CAPTURE,  32'hFFFF_FFFF,   1'b0, '0},
      '{OP_CAPTURE,  32'hFFFF_FFFF,   1'b1, '{1'b0, 1'b0, 8'd255}}  // largest echo time
   };

   ultrasonic_echo_ranger dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_capture_count  (req_capture_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_trigger_level  (rsp_trigger_level),
      .rsp_timer_enable   (rsp_timer_enable),
      .rsp_distance_value (rsp_distance_value)
   );

   always #4 clock = ~clock;

   // timer ticks per inch; a zero rate counts as one
   function automatic logic [COUNT_WIDTH-1:0] ticks_per_inch();
      logic [COUNT_WIDTH-1:0] rate;
      rate = (tick_rate == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(tick_rate);
      return rate * INCH_DIVISOR;
   endfunction

   // advances the predicted sequencer by one request beat and returns the reading it gives
   function automatic reading_type advance_ranger(input logic op,
                                                  input logic [COUNT_WIDTH-1:0] cnt);
      logic [COUNT_WIDTH-1:0] inches;
      reading_type            r;
      if (op == OP_RUN_TICK) begin
         if (seq_phase == PH_IDLE) begin
            trig_pin  = 1'b1;
            seq_phase = PH_TRIG;
         end else if (seq_phase == PH_TRIG) begin
            trig_pin  = 1'b0;
            seq_phase = PH_RELEASED;
         end
      end else if (seq_phase == PH_RELEASED) begin
         timer_on  = 1'b1;
         seq_phase = PH_RUNNING;
      end else if (seq_phase == PH_RUNNING) begin
         // one division by rate*148 equals the two truncating ones
         inches = cnt / ticks_per_inch();
         if (inches > MAX_INCHES) begin
            skip_next     = 1'b1;
            held_distance = DIST_WIDTH'(OUT_OF_RANGE);
         end else if (skip_next) begin
            // reading right after an out-of-range echo is thrown away
            skip_next     = 1'b0;
            held_distance = DIST_WIDTH'(OUT_OF_RANGE);
         end else begin
            held_distance = inches[DIST_WIDTH-1:0];
         end
         timer_on  = 1'b0;
         seq_phase = PH_IDLE;
      end
      r.trigger  = trig_pin;
      r.timer    = timer_on;
      r.distance = held_distance;
      return r;
   endfunction

   // echo time for the measuring edge: mostly in range, some at the boundary, some far out
   function automatic logic [COUNT_WIDTH-1:0] pick_echo_count();
      logic [COUNT_WIDTH-1:0] span;
      int unsigned            roll;
      span = ticks_per_inch();
      roll = $urandom_range(99);
      if (roll < 8) begin
         return $urandom;
      end else if (roll < 24) begin
         return $urandom_range(MAX_INCHES + 2, MAX_INCHES - 1) * span
                + $urandom_range(span - 1, 0);
      end else if (roll < 28) begin
         return $urandom_range(5000, MAX_INCHES + 1) * span + $urandom_range(span - 1, 0);
      end else begin
         return $urandom_range(MAX_INCHES, 0) * span + $urandom_range(span - 1, 0);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns  mismatch on %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // presents one request beat from a falling edge and returns at the falling edge after accept
   task automatic send_beat(input logic op, input logic [COUNT_WIDTH-1:0] cnt,
                            input logic pinned, input reading_type want);
      if (!quiet && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_capture_count <= cnt;
      row_pinned        <= pinned;
      row_want          <= want;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // drops valid and waits until every reading is in, then lets the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_tick_rate(input logic [TPU_WIDTH-1:0] rate);
      csr_write_enable <= 1'b1;
      csr_write_data   <= rate;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tick_rate         = rate;
   endtask

   // result side stalls about one cycle in ten, except in the quiet phase
   always @(negedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < 10);

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, expected_readings.size());
         $display("ultrasonic_echo_ranger_test: errors");
         $finish;
      end
   end

   // both handshakes sampled at the rising edge; request side first so a reading never
   // arrives ahead of its own prediction
   always @(posedge clock) begin
      reading_type predicted;
      reading_type got;
      reading_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            // predictor always advances, pinned rows just override what is checked
            predicted = advance_ranger(req_opcode, req_capture_count);
            expected_readings.push_back(row_pinned ? row_want : predicted);
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_trigger_level, rsp_timer_enable, rsp_distance_value};
            beats_out++;
            if (expected_readings.size() == 0) begin
               report_mismatch("beat with nothing expected", 32'(got), '0);
            end else begin
               want = expected_readings.pop_front();
               if (got.trigger !== want.trigger)
                  report_mismatch("trigger_level", 32'(got.trigger), 32'(want.trigger));
               if (got.timer !== want.timer)
                  report_mismatch("timer_enable", 32'(got.timer), 32'(want.timer));
               if (got.distance !== want.distance)
                  report_mismatch("distance_value", 32'(got.distance), 32'(want.distance));
            end
         end
      end
   end

   initial begin
      logic [TPU_WIDTH-1:0] rates [PHASE_COUNT];
      int unsigned          sent;
      // extremes first, zero is taken as one, then two random rates and back to reset value
      rates[0] = 8'd1;
      rates[1] = 8'd255;
      rates[2] = 8'd0;
      rates[3] = TPU_WIDTH'($urandom_range(254, 2));
      rates[4] = TPU_WIDTH'($urandom_range(254, 2));
      rates[5] = TPU_WIDTH'(TPU_RESET);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].opcode, directed_rows[i].count,
                   directed_rows[i].pinned, directed_rows[i].want);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         write_tick_rate(rates[p]);
         // one whole phase with no idle cycles on either side
         quiet = (p == QUIET_PHASE);
         sent  = 0;
         while (sent < ITEMS_A_PHASE) begin
            if ($urandom_range(99) < 15) begin
               // stray beat, breaks whatever cycle is under way
               send_beat($urandom_range(1, 0) ? OP_CAPTURE : OP_RUN_TICK, $urandom, 1'b0, '0);
               sent++;
            end else begin
               // full measure cycle: trigger up, release, timer start, echo
               send_beat(OP_RUN_TICK, $urandom, 1'b0, '0);
               send_beat(OP_RUN_TICK, $urandom, 1'b0, '0);
               send_beat(OP_CAPTURE, $urandom, 1'b0, '0);
               send_beat(OP_CAPTURE, pick_echo_count(), 1'b0, '0);
               echoes_sent++;
               sent += 4;
            end
         end
      end
      quiet = 1'b0;
      wait_idle();

      $display("run covered %0d request beats and %0d reading beats, %0d echo cycles",
               beats_in, beats_out, echoes_sent);
      $display("tick rates 16 then %0d %0d %0d %0d %0d %0d, with and without idle gaps",
               rates[0], rates[1], rates[2], rates[3], rates[4], rates[5]);
      if (mismatch_count == 0) begin
         $display("ultrasonic_echo_ranger_test: clean");
      end else begin
         $display("ultrasonic_echo_ranger_test: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/uer_pkg.sv
hdl/uer_controller.sv
hdl/uer_datapath.sv
hdl/ultrasonic_echo_ranger.sv
tb/sv/ultrasonic_echo_ranger_test.sv
